### sv/badt_pkg.sv
// Shared types, constants and rectangle helpers for the buffer age damage tracker.
// Used by badt_cell and buffer_age_damage_tracker_top; depends on nothing else.
package badt_pkg;

  // Number of frame boxes kept in the history chain
  localparam int HistDepth = 10;
  // Fill count holds 0..HistDepth
  localparam int CntW      = $clog2(HistDepth + 1);
  // Walk step counter indexes 0..HistDepth-1
  localparam int StepW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;

  localparam int CoordW    = 16;
  localparam int SizeW     = 15;
  localparam int AddrW     = 4;
  localparam int DataW     = 32;
  localparam int InDataW   = 80;
  localparam int OutDataW  = 64;

  typedef struct packed {
    logic signed [CoordW-1:0] b;
    logic signed [CoordW-1:0] r;
    logic signed [CoordW-1:0] t;
    logic signed [CoordW-1:0] l;
  } box_t;

  typedef enum logic [1:0] {
    OP_RECORD = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_FULL   = 2'd1,
    KIND_MERGED = 2'd2
  } region_kind_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_PUSH   = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_mode_e;

  typedef enum logic [1:0] {
    REG_PARTIAL = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    region_kind_e kind;
    box_t         box;
  } result_t;

  // A box is empty when right <= left or bottom <= top
  function automatic logic box_empty(box_t a);
    return ($signed(a.r) <= $signed(a.l)) || ($signed(a.b) <= $signed(a.t));
  endfunction

  // Bounding box of two boxes; an empty operand leaves the other one
  function automatic box_t box_union(box_t a, box_t c);
    box_t m;
    if (box_empty(a)) begin
      m = c;
    end else if (box_empty(c)) begin
      m = a;
    end else begin
      m.l = ($signed(a.l) < $signed(c.l)) ? a.l : c.l;
      m.t = ($signed(a.t) < $signed(c.t)) ? a.t : c.t;
      m.r = ($signed(a.r) > $signed(c.r)) ? a.r : c.r;
      m.b = ($signed(a.b) > $signed(c.b)) ? a.b : c.b;
    end
    return m;
  endfunction

  // Full-surface answer; a zero-size surface reports no damage
  function automatic result_t full_result(logic [SizeW-1:0] w, logic [SizeW-1:0] h);
    result_t res;
    res = '0;
    if ((w != '0) && (h != '0)) begin
      res.kind  = KIND_FULL;
      res.box.r = {1'b0, w};
      res.box.b = {1'b0, h};
    end else begin
      res.kind  = KIND_NONE;
    end
    return res;
  endfunction

endpackage

### sv/buffer_age_damage_tracker_top.sv
// Buffer age damage tracker: record, clear and query of per-frame damage boxes.
// Record and clear words may follow back to back.
// A query that is decided at once goes from the emit state into the output register when it is free; one that
// merges history first rotates the cell chain once through all its cells in the walk state.
// The input is not ready in the walk or emit state. Reset clears fill count, frame box,
// configuration and handshake state; history cells hold whatever was last pushed.
module buffer_age_damage_tracker_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] rect_left, [31:16] rect_top, [47:32] rect_right, [63:48] rect_bottom,
  // [71:64] buffer_age, [72] age_valid, [73] fbo_nonzero, [79:74] zero
  input  logic [badt_pkg::InDataW-1:0]  s_axis_tdata_i,
  // [1:0] opcode
  input  logic [1:0]                    s_axis_tuser_i,
  // last_rect
  input  logic                          s_axis_tlast_i,
  // Result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] out_left, [31:16] out_top, [47:32] out_right, [63:48] out_bottom
  output logic [badt_pkg::OutDataW-1:0] m_axis_tdata_o,
  // [1:0] region_kind
  output logic [1:0]                    m_axis_tuser_o,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [badt_pkg::AddrW-1:0]    paddr,
  input  logic [badt_pkg::DataW-1:0]    pwdata,
  output logic [badt_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic                         partial_q;
  logic [badt_pkg::SizeW-1:0]   width_q;
  logic [badt_pkg::SizeW-1:0]   height_q;

  logic [badt_pkg::CntW-1:0]    count_q, count_d;
  logic [badt_pkg::CntW-1:0]    need_q, need_d;
  logic [badt_pkg::StepW-1:0]   step_q, step_d;
  badt_pkg::box_t               frame_q, frame_d;
  badt_pkg::box_t               acc_q, acc_d;
  badt_pkg::result_t            res_q, res_d;
  badt_pkg::result_t            out_q;
  logic                         out_valid_q, out_valid_d;
  logic                         out_load;

  badt_pkg::cell_mode_e         cell_mode;
  badt_pkg::box_t               push_box;
  badt_pkg::box_t               cells [badt_pkg::HistDepth];

  logic                         in_fire;
  badt_pkg::opcode_e            opcode;
  badt_pkg::box_t               rect_in;
  badt_pkg::box_t               rect_merged;
  logic signed [7:0]            buffer_age;
  logic [7:0]                   need_wide;
  logic                         age_valid;
  logic                         fbo_nonzero;

  logic                         cfg_write;
  badt_pkg::cfg_reg_e           cfg_sel;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = badt_pkg::cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= 1'b0;
      width_q   <= '0;
      height_q  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        badt_pkg::REG_PARTIAL: partial_q <= pwdata[0];
        badt_pkg::REG_WIDTH:   width_q   <= pwdata[badt_pkg::SizeW-1:0];
        badt_pkg::REG_HEIGHT:  height_q  <= pwdata[badt_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      badt_pkg::REG_PARTIAL: prdata[0]                   = partial_q;
      badt_pkg::REG_WIDTH:   prdata[badt_pkg::SizeW-1:0] = width_q;
      badt_pkg::REG_HEIGHT:  prdata[badt_pkg::SizeW-1:0] = height_q;
      default:               prdata = '0;
    endcase
  end

  // Unpack the input word
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign opcode          = badt_pkg::opcode_e'(s_axis_tuser_i);
  assign rect_in         = s_axis_tdata_i[63:0];
  assign buffer_age      = s_axis_tdata_i[71:64];
  assign age_valid       = s_axis_tdata_i[72];
  assign fbo_nonzero     = s_axis_tdata_i[73];
  assign need_wide       = buffer_age - 8'sd1;

  // Fold the incoming rectangle into the frame box, skipping empty ones
  assign rect_merged = badt_pkg::box_empty(rect_in) ? frame_q
                                                    : badt_pkg::box_union(frame_q, rect_in);
  assign push_box    = rect_merged;

  // Control: decode words, walk the chain, hand the result to the output
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    need_d    = need_q;
    step_d    = step_q;
    frame_d   = frame_q;
    acc_d     = acc_q;
    res_d     = res_q;
    cell_mode = badt_pkg::CELL_HOLD;
    out_load  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (opcode)
            badt_pkg::OP_RECORD: begin
              if (s_axis_tlast_i) begin
                cell_mode = badt_pkg::CELL_PUSH;
                frame_d   = '0;
                if (count_q != badt_pkg::CntW'(badt_pkg::HistDepth)) begin
                  count_d = count_q + 1'b1;
                end
              end else begin
                frame_d = rect_merged;
              end
            end
            badt_pkg::OP_CLEAR: begin
              count_d = '0;
            end
            badt_pkg::OP_QUERY: begin
              state_d = ST_EMIT;
              if (!partial_q || fbo_nonzero) begin
                res_d = badt_pkg::full_result(width_q, height_q);
              end else if (!age_valid || (buffer_age <= 8'sd0)) begin
                count_d = '0;
                res_d   = badt_pkg::full_result(width_q, height_q);
              end else if (buffer_age == 8'sd1) begin
                res_d = '0;
              end else if (need_wide > 8'(count_q)) begin
                res_d = badt_pkg::full_result(width_q, height_q);
              end else begin
                need_d  = need_wide[badt_pkg::CntW-1:0];
                step_d  = '0;
                acc_d   = '0;
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      ST_WALK: begin
        // Cell zero shows entry step_q (newest first) as the chain rotates
        cell_mode = badt_pkg::CELL_ROTATE;
        if (badt_pkg::CntW'(step_q) < need_q) begin
          acc_d = badt_pkg::box_union(acc_q, cells[0]);
        end
        if (step_q == badt_pkg::StepW'(badt_pkg::HistDepth - 1)) begin
          state_d = ST_EMIT;
          if (badt_pkg::box_empty(acc_d)) begin
            res_d = '0;
          end else begin
            res_d.kind = badt_pkg::KIND_MERGED;
            res_d.box  = acc_d;
          end
        end else begin
          step_d = step_q + 1'b1;
        end
      end

      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Output register holds a result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    step_q <= step_d;
    acc_q  <= acc_d;
    res_q  <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_q.box.b, out_q.box.r, out_q.box.t, out_q.box.l};
  assign m_axis_tuser_o  = out_q.kind;

  // History chain: cell zero is the newest frame; a push moves every box one
  // cell older, a rotation moves every box one cell newer with wraparound
  for (genvar g = 0; g < badt_pkg::HistDepth; g++) begin : g_cell
    badt_cell u_cell (
      .clk_i   (clk_i),
      .mode_i  (cell_mode),
      .lower_i ((g == 0) ? push_box
                         : cells[(g == 0) ? (badt_pkg::HistDepth - 1) : (g - 1)]),
      .upper_i (cells[(g == badt_pkg::HistDepth - 1) ? 0 : (g + 1)]),
      .box_o   (cells[g])
    );
  end

endmodule

### sv/badt_cell.sv
// One history cell: holds one frame box and passes it to a neighbor.
// Depends on badt_pkg for box_t and cell_mode_e.
module badt_cell (
  input  logic                 clk_i,
  input  badt_pkg::cell_mode_e mode_i,
  input  badt_pkg::box_t       lower_i,
  input  badt_pkg::box_t       upper_i,
  output badt_pkg::box_t       box_o
);

  badt_pkg::box_t box_q;
  badt_pkg::box_t box_d;

  // Take from the newer neighbor on a push, from the older one on a rotation
  always_comb begin
    box_d = box_q;
    unique case (mode_i)
      badt_pkg::CELL_HOLD:   box_d = box_q;
      badt_pkg::CELL_PUSH:   box_d = lower_i;
      badt_pkg::CELL_ROTATE: box_d = upper_i;
      default:               box_d = box_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign box_o = box_q;

endmodule

### verif/buffer_age_damage_tracker_top_tb.sv
// Self-checking testbench for buffer_age_damage_tracker_top: directed table, then random
// frames and queries under several idle and stall patterns. Depends on badt_pkg and the RTL.
`timescale 1ns / 100ps

module buffer_age_damage_tracker_top_tb;

  localparam int QuietLimit   = 3000;
  localparam int SettleCycles = 16;
  localparam int TailCycles   = 24;
  localparam int HoldCycles   = 400;
  localparam int PlanRows     = 32;
  localparam int DueDepth     = 64;

  // One input word as the block sees it
  typedef struct {
    badt_pkg::opcode_e     op;
    badt_pkg::box_t        rect;
    logic                  last;
    logic signed [7:0]     age;
    logic                  age_ok;
    logic                  fbo;
  } damage_word_t;

  // Directed row: word plus an answer typed in where it is obvious
  typedef struct {
    damage_word_t      w;
    bit                typed;
    badt_pkg::result_t want;
  } plan_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid_i = 1'b0;
  logic                          s_axis_tready_o;
  // [15:0] rect_left, [31:16] rect_top, [47:32] rect_right, [63:48] rect_bottom,
  // [71:64] buffer_age, [72] age_valid, [73] fbo_nonzero, [79:74] zero
  logic [badt_pkg::InDataW-1:0]  s_axis_tdata_i = '0;
  // [1:0] opcode
  logic [1:0]                    s_axis_tuser_i = '0;
  logic                          s_axis_tlast_i = 1'b0;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i = 1'b0;
  // [15:0] out_left, [31:16] out_top, [47:32] out_right, [63:48] out_bottom
  logic [badt_pkg::OutDataW-1:0] m_axis_tdata_o;
  // [1:0] region_kind
  logic [1:0]                    m_axis_tuser_o;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [badt_pkg::AddrW-1:0]    paddr = '0;
  logic [badt_pkg::DataW-1:0]    pwdata = '0;
  logic [badt_pkg::DataW-1:0]    prdata;
  logic                          pready;

  // Predictor state
  badt_pkg::box_t                hist_box [badt_pkg::HistDepth];
  int                            hist_fill;
  int                            hist_next;
  badt_pkg::box_t                frame_box;
  logic                          cfg_partial;
  logic [badt_pkg::SizeW-1:0]    cfg_width;
  logic [badt_pkg::SizeW-1:0]    cfg_height;

  // Pending answers, oldest at due_head
  badt_pkg::result_t             due_ring [DueDepth];
  int                            due_head = 0;
  int                            due_tail = 0;

  plan_row_t                     plan_rows [PlanRows];
  int                            plan_len = 0;

  int                            mismatches;
  int                            send_idle_pct;
  int                            stall_pct;
  int                            hold_ask;
  int                            hold_seen;
  int                            hold_left;
  int                            quiet;

  buffer_age_damage_tracker_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic rect_void(badt_pkg::box_t a);
    return ($signed(a.r) <= $signed(a.l)) || ($signed(a.b) <= $signed(a.t));
  endfunction

  function automatic badt_pkg::box_t rect_merge(badt_pkg::box_t a, badt_pkg::box_t c);
    badt_pkg::box_t m;
    if (rect_void(a)) return c;
    if (rect_void(c)) return a;
    m.l = ($signed(a.l) < $signed(c.l)) ? a.l : c.l;
    m.t = ($signed(a.t) < $signed(c.t)) ? a.t : c.t;
    m.r = ($signed(a.r) > $signed(c.r)) ? a.r : c.r;
    m.b = ($signed(a.b) > $signed(c.b)) ? a.b : c.b;
    return m;
  endfunction

  // Full surface, or nothing when the surface has no area
  function automatic badt_pkg::result_t surface_answer();
    badt_pkg::result_t res;
    res = '0;
    if (cfg_width != '0 && cfg_height != '0) begin
      res.kind  = badt_pkg::KIND_FULL;
      res.box.r = {1'b0, cfg_width};
      res.box.b = {1'b0, cfg_height};
    end
    return res;
  endfunction

  // Advance the tracker copy by one word; a query yields one answer
  task automatic predict_damage(input damage_word_t w, output bit has,
                                output badt_pkg::result_t res);
    badt_pkg::box_t acc;
    int             need;
    int             slot;
    has = 1'b0;
    res = '0;
    case (w.op)
      badt_pkg::OP_RECORD: begin
        if (!rect_void(w.rect)) frame_box = rect_merge(frame_box, w.rect);
        if (w.last) begin
          hist_box[hist_next] = frame_box;
          hist_next = (hist_next + 1) % badt_pkg::HistDepth;
          if (hist_fill < badt_pkg::HistDepth) hist_fill++;
          frame_box = '0;
        end
      end
      badt_pkg::OP_CLEAR: begin
        hist_fill = 0;
        hist_next = 0;
      end
      badt_pkg::OP_QUERY: begin
        has = 1'b1;
        if (!cfg_partial || w.fbo) begin
          res = surface_answer();
        end else if (!w.age_ok || w.age <= 0) begin
          hist_fill = 0;
          hist_next = 0;
          res = surface_answer();
        end else if (w.age == 1) begin
          res = '0;
        end else begin
          need = int'(w.age) - 1;
          if (need > hist_fill) begin
            res = surface_answer();
          end else begin
            acc = '0;
            for (int i = 0; i < need; i++) begin
              slot = (hist_next + badt_pkg::HistDepth - 1 - i) % badt_pkg::HistDepth;
              acc = rect_merge(acc, hist_box[slot]);
            end
            if (!rect_void(acc)) begin
              res.kind = badt_pkg::KIND_MERGED;
              res.box  = acc;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side and result checking
  // ---------------------------------------------------------------------------

  // Stall at random; hold off for a long stretch on request
  always @(posedge clk_i) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result word against the oldest pending answer
  always @(posedge clk_i) begin : check_results
    badt_pkg::result_t want;
    badt_pkg::box_t    got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (due_tail == due_head) begin
        $error("result word with no query pending: kind %0d", m_axis_tuser_o);
        mismatches++;
      end else begin
        want = due_ring[due_head % DueDepth];
        due_head++;
        check_field("region_kind", int'(want.kind), int'(m_axis_tuser_o));
        check_field("out_left", int'(want.box.l), int'(got.l));
        check_field("out_top", int'(want.box.t), int'(got.t));
        check_field("out_right", int'(want.box.r), int'(got.r));
        check_field("out_bottom", int'(want.box.b), int'(got.b));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i) || (psel && penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QuietLimit) begin
      $display("buffer_age_damage_tracker_top regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  function automatic damage_word_t mk(badt_pkg::opcode_e op, int l, int t, int r, int b,
                                      logic last, int age, logic age_ok, logic fbo);
    damage_word_t w;
    w.op     = op;
    w.rect.l = badt_pkg::CoordW'(l);
    w.rect.t = badt_pkg::CoordW'(t);
    w.rect.r = badt_pkg::CoordW'(r);
    w.rect.b = badt_pkg::CoordW'(b);
    w.last   = last;
    w.age    = 8'(age);
    w.age_ok = age_ok;
    w.fbo    = fbo;
    return w;
  endfunction

  function automatic badt_pkg::result_t ans(badt_pkg::region_kind_e kind, int l, int t,
                                            int r, int b);
    badt_pkg::result_t res;
    res.kind  = kind;
    res.box.l = badt_pkg::CoordW'(l);
    res.box.t = badt_pkg::CoordW'(t);
    res.box.r = badt_pkg::CoordW'(r);
    res.box.b = badt_pkg::CoordW'(b);
    return res;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(damage_word_t w, bit typed, badt_pkg::result_t want);
    plan_rows[plan_len].w     = w;
    plan_rows[plan_len].typed = typed;
    plan_rows[plan_len].want  = want;
    plan_len++;
  endfunction

  // Offer one word after a random gap and wait until it is taken
  task automatic offer(input damage_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, w.fbo, w.age_ok, w.age, w.rect};
    s_axis_tuser_i  <= w.op;
    s_axis_tlast_i  <= w.last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_word(input damage_word_t w, input bit typed,
                           input badt_pkg::result_t want);
    bit                has;
    badt_pkg::result_t res;
    offer(w);
    predict_damage(w, has, res);
    if (has) begin
      due_ring[due_tail % DueDepth] = typed ? want : res;
      due_tail++;
    end
  endtask

  task automatic apb_write(input badt_pkg::cfg_reg_e r, input logic [badt_pkg::DataW-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= badt_pkg::AddrW'(int'(r) * 4);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_check(input badt_pkg::cfg_reg_e r, input logic [badt_pkg::DataW-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= badt_pkg::AddrW'(int'(r) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== v) begin
      $error("prdata of %s: expected %0d, got %0d", r.name(), v, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drain, let the block settle, then write and read back all registers
  task automatic program_regs(input logic part, input int w, input int h);
    s_axis_tvalid_i <= 1'b0;
    while (due_tail != due_head) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    apb_write(badt_pkg::REG_PARTIAL, badt_pkg::DataW'(part));
    apb_write(badt_pkg::REG_WIDTH, badt_pkg::DataW'(w));
    apb_write(badt_pkg::REG_HEIGHT, badt_pkg::DataW'(h));
    apb_check(badt_pkg::REG_PARTIAL, badt_pkg::DataW'(part));
    apb_check(badt_pkg::REG_WIDTH, badt_pkg::DataW'(w));
    apb_check(badt_pkg::REG_HEIGHT, badt_pkg::DataW'(h));
    cfg_partial = part;
    cfg_width   = badt_pkg::SizeW'(w);
    cfg_height  = badt_pkg::SizeW'(h);
  endtask

  function automatic badt_pkg::box_t rand_rect();
    badt_pkg::box_t b;
    int             x;
    int             y;
    if ($urandom_range(7) == 0) begin
      b = {$urandom, $urandom};
    end else begin
      x   = int'($urandom_range(0, 4000)) - 2000;
      y   = int'($urandom_range(0, 4000)) - 2000;
      b.l = badt_pkg::CoordW'(x);
      b.t = badt_pkg::CoordW'(y);
      b.r = badt_pkg::CoordW'(x + int'($urandom_range(0, 400)) - 20);
      b.b = badt_pkg::CoordW'(y + int'($urandom_range(0, 400)) - 20);
    end
    return b;
  endfunction

  // Mostly whole frames and well-formed queries, with clears and noise mixed in
  task automatic random_chunk(input int n);
    damage_word_t w;
    int           sent;
    int           pick;
    int           k;
    sent = 0;
    while (sent < n) begin
      pick     = $urandom_range(99);
      w.rect   = {$urandom, $urandom};
      w.last   = 1'($urandom_range(1));
      w.age    = 8'($urandom);
      w.age_ok = 1'($urandom_range(1));
      w.fbo    = 1'($urandom_range(1));
      if (pick < 55) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          w.op   = badt_pkg::OP_RECORD;
          w.rect = rand_rect();
          w.last = (i == k - 1);
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else begin
        if (pick < 85) begin
          w.op     = badt_pkg::OP_QUERY;
          w.age_ok = ($urandom_range(99) >= 5);
          w.fbo    = ($urandom_range(99) < 5);
          if ($urandom_range(99) < 85) w.age = 8'($urandom_range(0, 12));
        end else if (pick < 90) begin
          w.op = badt_pkg::OP_CLEAR;
        end else if (pick < 95) begin
          w.op = badt_pkg::OP_NONE;
        end else begin
          w.op = badt_pkg::opcode_e'($urandom_range(0, 3));
        end
        send_word(w, 1'b0, '0);
        if (w.op != badt_pkg::OP_NONE) sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    hist_fill     = 0;
    hist_next     = 0;
    frame_box     = '0;
    cfg_partial   = 1'b0;
    cfg_width     = '0;
    cfg_height    = '0;
    mismatches    = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_ask      = 0;
    hold_seen     = 0;
    hold_left     = 0;
    quiet         = 0;

    // Rows 0 and 1 run on the reset settings; the rest after the first write
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 1,
            ans(badt_pkg::KIND_NONE, 0, 0, 0, 0));
    add_row(mk(badt_pkg::OP_RECORD, -32768, -32768, 32767, 32767, 1, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 1), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 3, 0, 0), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, 1, 0), 1,
            ans(badt_pkg::KIND_NONE, 0, 0, 0, 0));
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    // Empty frame, then a frame built from two corner boxes and an inverted one
    add_row(mk(badt_pkg::OP_RECORD, 5, 5, 5, 9, 1, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 0, '0);
    add_row(mk(badt_pkg::OP_RECORD, -32768, -32768, -32767, -32767, 0, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_RECORD, 32766, 32766, 32767, 32767, 0, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_RECORD, 10, 20, 5, 30, 1, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 3, 1, 0), 0, '0);
    // Ignored opcode with every field bit set
    add_row(mk(badt_pkg::OP_NONE, -1, -1, -1, -1, 1, -1, 1, 1), 0, '0);
    // Nonpositive ages empty the history
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 1, 0), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, -128, 1, 0), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    add_row(mk(badt_pkg::OP_RECORD, 1, 2, 3, 4, 1, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 127, 1, 0), 1,
            ans(badt_pkg::KIND_FULL, 0, 0, 32767, 32767));
    // A clear keeps the frame box that is being built
    add_row(mk(badt_pkg::OP_RECORD, 0, 0, 1, 1, 0, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_RECORD, 2, 2, 3, 3, 1, 0, 0, 0), 0, '0);
    add_row(mk(badt_pkg::OP_QUERY, 0, 0, 0, 0, 0, 2, 1, 0), 0, '0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < plan_len; i++) begin
      if (i == 2) program_regs(1'b1, 32767, 32767);
      send_word(plan_rows[i].w, plan_rows[i].typed, plan_rows[i].want);
    end

    program_regs(1'b1, 1920, 1080);
    random_chunk(220);

    program_regs(1'b1, 32767, 0);
    send_idle_pct = 76;
    random_chunk(220);

    program_regs(1'b1, 0, 32767);
    send_idle_pct = 0;
    stall_pct     = 76;
    random_chunk(220);

    program_regs(1'b1, 1, 1);
    send_idle_pct = 15;
    stall_pct     = 15;
    random_chunk(220);

    // Hold the result side off while words keep coming
    program_regs(1'b1, 800, 600);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_ask++;
    random_chunk(100);

    program_regs(1'b0, 32767, 32767);
    send_idle_pct = 15;
    stall_pct     = 15;
    random_chunk(60);

    // Drain and let any stray word show up
    s_axis_tvalid_i <= 1'b0;
    while (due_tail != due_head) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("buffer_age_damage_tracker_top regression: pass");
    end else begin
      $display("buffer_age_damage_tracker_top regression: fail");
    end
    $finish;
  end

endmodule

### buffer_age_damage_tracker_top.f
sv/badt_pkg.sv
sv/badt_cell.sv
sv/buffer_age_damage_tracker_top.sv
verif/buffer_age_damage_tracker_top_tb.sv
